[design/bcc_pkg.sv]
package bcc_pkg;

    localparam int MaxSamples = 1024;
    localparam int AddrW      = $clog2(MaxSamples);
    localparam int CntW       = AddrW + 1;

    localparam logic [15:0] DivisorReset = 16'd1024;

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        S_LOAD   = 9'b000000001,
        S_MEAN   = 9'b000000010,
        S_VARRD  = 9'b000000100,
        S_VAR    = 9'b000001000,
        S_VDIV   = 9'b000010000,
        S_SQRT   = 9'b000100000,
        S_STUD   = 9'b001000000,
        S_CMP    = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    // Request to the shared restoring divider.
    typedef struct packed {
        logic         start;
        logic         neg;     // quotient sign, truncated toward zero
        logic [63:0]  num;     // magnitude of numerator
        logic [63:0]  den;     // nonzero magnitude of denominator
    } t_div_req;

    typedef struct packed {
        logic         done;
        logic         busy;
        logic [63:0]  quo;     // magnitude of quotient
        logic         neg;
    } t_div_rsp;

endpackage

[design/bcc_ram.sv]
module bcc_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/bcc_div.sv]
// Shared restoring divider: one quotient bit per cycle over 64 bits.
module bcc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bcc_pkg::t_div_req  i_req,
    output bcc_pkg::t_div_rsp  o_rsp
);

    logic [63:0] r_quo, n_quo;
    logic [64:0] r_rem, n_rem;
    logic [63:0] r_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic        r_neg;
    logic [64:0] w_trial;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem[63:0], r_quo[63]} - {1'b0, r_den};
        if (r_busy) begin
            if (!w_trial[64]) begin
                n_rem = w_trial;
                n_quo = {r_quo[62:0], 1'b1};
            end else begin
                n_rem = {r_rem[63:0], r_quo[63]};
                n_quo = {r_quo[62:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= 7'd64;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
            r_neg <= i_req.neg;
        end else begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.busy = r_busy;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.neg  = r_neg;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without run");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while busy");
    a_cnt_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_cnt == 7'd0) else $error("divider count left over");
`endif

endmodule

[design/bootstrap_column_calibration_core.sv]
// Bootstrap column calibration. Samples stream in one beat per cycle and are
// written to a 1024-entry sample RAM while a 48-bit running sum is kept. The
// beat flagged by tlast closes the column: the block drops s_axis_tready and
// a small sequencer runs the end-of-column work on one shared 64-bit restoring
// divider (one bit per cycle) and one 32x32 multiplier. The mean takes one
// divide, a reread of the RAM accumulates squared deviations, the variance
// takes a divide, the square root is formed one bit per step, the studentized
// value takes a divide unless the sd is zero, a second RAM reread counts
// reflected samples below the basic pivot, and a final divide forms the below
// fraction. Then one result beat is offered on the master side; the block
// waits there until it is taken. The divisor register may be written only
// while the block is idle; values 0 and 1 act as 2. Values are signed Q16.16,
// std_dev is Q15.16 unsigned and below_fraction is Q1.16 saturated at one.
module bootstrap_column_calibration_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata,     // sample_divisor
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] sample, [63:32] est_full, [95:64] est_first, [103:96] column_index
    input  logic [103:0] s_axis_tdata,
    input  logic         s_axis_tlast,    // last_sample
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [7:0] column_out, [39:8] basic_pivot, [71:40] studentized,
    // [102:72] std_dev, [113:103] below_count, [130:114] below_fraction,
    // [131] sd_zero, [135:132] zero
    output logic [135:0] m_axis_tdata
);

    localparam int AW = bcc_pkg::AddrW;
    localparam int CW = bcc_pkg::CntW;

    bcc_pkg::t_state r_state;
    logic [15:0]     r_divisor;
    logic [47:0]     r_sum;
    logic [CW-1:0]   r_loaded;
    logic [CW-1:0]   r_idx;
    logic signed [31:0] r_full, r_first, r_mean;
    logic [7:0]      r_col;
    logic [63:0]     r_acc;
    logic [63:0]     r_var;
    logic [31:0]     r_root;
    logic [33:0]     r_rem;
    logic [5:0]      r_step;
    logic [63:0]     r_sq;
    logic            r_sqv;
    logic [1:0]      r_rdv;
    logic [10:0]     r_cnt;
    logic signed [31:0] r_stud;
    logic [16:0]     r_frac;
    logic            r_issued;

    logic            w_in_acc, w_out_acc, w_full_store;
    logic [31:0]     w_rdata;
    logic [AW-1:0]   w_raddr;
    logic [15:0]     w_div;
    bcc_pkg::t_div_req w_req;
    bcc_pkg::t_div_rsp w_rsp;
    logic signed [32:0] w_dev;
    logic [32:0]     w_mag;
    logic [64:0]     w_accsum;
    logic signed [33:0] w_pivot, w_refl;
    logic signed [32:0] w_diff;
    logic [63:0]     w_qsat;
    logic [33:0]     w_trial;
    logic [47:0]     w_summag;

    assign s_axis_tready = (r_state == bcc_pkg::S_LOAD);
    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;
    assign w_full_store = r_loaded[CW-1];
    assign w_div = (r_divisor < 16'd2) ? 16'd2 : r_divisor;

    assign w_raddr = r_idx[AW-1:0];

    bcc_ram #(.Width(32), .Depth(bcc_pkg::MaxSamples)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && !w_full_store),
        .i_waddr (r_loaded[AW-1:0]),
        .i_wdata (s_axis_tdata[31:0]),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    bcc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_pivot  = 34'(r_full) + 34'(r_full) - 34'(r_first);
    assign w_refl   = 34'(r_first) + 34'(r_first) - 34'(signed'(w_rdata));
    assign w_dev    = 33'(signed'(w_rdata)) - 33'(r_mean);
    assign w_mag    = w_dev[32] ? 33'(-w_dev) : 33'(w_dev);
    assign w_accsum = {1'b0, r_acc} + {1'b0, r_sq};
    assign w_diff   = 33'(r_first) - 33'(r_full);
    assign w_summag = r_sum[47] ? -r_sum : r_sum;
    // Square root: one result bit per step, two radicand bits consumed.
    assign w_trial  = {r_rem[31:0], r_var[63:62]} - {r_root, 2'b01};

    // Each divide state starts the divider in its first cycle (S_STUD: sd > 0).
    always_comb begin
        w_req = '0;
        if (!r_issued) begin
            case (r_state)
                bcc_pkg::S_MEAN: begin
                    w_req.start = 1'b1;
                    w_req.neg   = r_sum[47];
                    w_req.num   = 64'(w_summag);
                    w_req.den   = 64'(w_div);
                end
                bcc_pkg::S_VDIV: begin
                    w_req.start = 1'b1;
                    w_req.num   = r_acc;
                    w_req.den   = 64'(w_div - 16'd1);
                end
                bcc_pkg::S_STUD: begin
                    // The divisor is the sd after its saturation to 31 bits.
                    w_req.start = (r_root != 32'd0);
                    w_req.neg   = w_diff[32];
                    w_req.num   = {15'd0, (w_diff[32] ? 33'(-w_diff) : 33'(w_diff)), 16'd0};
                    w_req.den   = r_root[31] ? 64'h7FFF_FFFF : 64'(r_root);
                end
                bcc_pkg::S_OUT: begin
                    w_req.start = 1'b1;
                    w_req.num   = {37'd0, r_cnt, 16'd0};
                    w_req.den   = 64'(w_div);
                end
                default: w_req = '0;
            endcase
        end
    end

    // Saturate a signed quotient to 32 bits.
    always_comb begin
        if (w_rsp.neg) begin
            w_qsat = (w_rsp.quo > 64'h8000_0000) ? 64'hFFFF_FFFF_8000_0000 : -w_rsp.quo;
        end else begin
            w_qsat = (w_rsp.quo > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : w_rsp.quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bcc_pkg::S_LOAD;
            r_divisor <= bcc_pkg::DivisorReset;
            r_sum     <= '0;
            r_loaded  <= '0;
            r_issued  <= 1'b0;
            m_axis_tvalid <= 1'b0;
            r_full    <= '0;
            r_first   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_divisor <= i_cfg_wdata;
            end
            if (w_req.start) begin
                r_issued <= 1'b1;
            end
            case (r_state)
                bcc_pkg::S_LOAD: begin
                    if (w_in_acc) begin
                        r_full  <= s_axis_tdata[63:32];
                        r_first <= s_axis_tdata[95:64];
                        r_col   <= s_axis_tdata[103:96];
                        if (!w_full_store) begin
                            r_sum    <= r_sum + 48'(signed'(s_axis_tdata[31:0]));
                            r_loaded <= r_loaded + CW'(1);
                        end
                        if (s_axis_tlast) begin
                            r_state  <= bcc_pkg::S_MEAN;
                            r_issued <= 1'b0;
                        end
                    end
                end
                bcc_pkg::S_MEAN: begin
                    if (w_rsp.done) begin
                        r_mean  <= w_qsat[31:0];
                        r_idx   <= '0;
                        r_acc   <= '0;
                        r_sqv   <= 1'b0;
                        r_rdv   <= '0;
                        r_state <= bcc_pkg::S_VARRD;
                    end
                end
                bcc_pkg::S_VARRD, bcc_pkg::S_VAR: begin
                    // Read, then square, then accumulate, one sample a cycle.
                    r_rdv[0] <= (r_idx < r_loaded);
                    r_rdv[1] <= r_rdv[0];
                    if (r_idx < r_loaded) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    r_sq  <= 64'(w_mag[31:0]) * 64'(w_mag[31:0]) |
                             (w_mag[32] ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd0);
                    r_sqv <= r_rdv[1];
                    if (r_rdv[1]) begin
                        r_acc <= w_accsum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : w_accsum[63:0];
                    end
                    if (r_state == bcc_pkg::S_VAR && !(r_idx < r_loaded) && r_rdv == 2'b00
                        && !r_sqv) begin
                        r_state  <= bcc_pkg::S_VDIV;
                        r_issued <= 1'b0;
                    end else begin
                        r_state <= bcc_pkg::S_VAR;
                    end
                end
                bcc_pkg::S_VDIV: begin
                    if (w_rsp.done) begin
                        r_var   <= w_rsp.quo;
                        r_root  <= '0;
                        r_rem   <= '0;
                        r_step  <= 6'd32;
                        r_state <= bcc_pkg::S_SQRT;
                    end
                end
                bcc_pkg::S_SQRT: begin
                    r_var <= {r_var[61:0], 2'b00};
                    if (!w_trial[33]) begin
                        r_rem  <= w_trial;
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_rem  <= {r_rem[31:0], r_var[63:62]};
                        r_root <= {r_root[30:0], 1'b0};
                    end
                    r_step <= r_step - 6'd1;
                    if (r_step == 6'd1) begin
                        r_state  <= bcc_pkg::S_STUD;
                        r_issued <= 1'b0;
                    end
                end
                bcc_pkg::S_STUD: begin
                    if (r_root == 32'd0) begin
                        r_stud  <= '0;
                        r_idx   <= '0;
                        r_cnt   <= '0;
                        r_rdv   <= '0;
                        r_state <= bcc_pkg::S_CMP;
                    end else if (w_rsp.done) begin
                        r_stud  <= w_qsat[31:0];
                        r_idx   <= '0;
                        r_cnt   <= '0;
                        r_rdv   <= '0;
                        r_state <= bcc_pkg::S_CMP;
                    end
                end
                bcc_pkg::S_CMP: begin
                    r_rdv[0] <= (r_idx < r_loaded);
                    if (r_idx < r_loaded) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if (r_rdv[0] && (w_refl < w_pivot)) begin
                        r_cnt <= r_cnt + 11'd1;
                    end
                    if (!(r_idx < r_loaded) && !r_rdv[0]) begin
                        r_state  <= bcc_pkg::S_OUT;
                        r_issued <= 1'b0;
                    end
                end
                bcc_pkg::S_OUT: begin
                    if (w_rsp.done) begin
                        r_frac <= (w_rsp.quo > 64'd65536) ? 17'd65536 : w_rsp.quo[16:0];
                        m_axis_tvalid <= 1'b1;
                    end
                    if (w_out_acc) begin
                        m_axis_tvalid <= 1'b0;
                        r_sum    <= '0;
                        r_loaded <= '0;
                        r_state  <= bcc_pkg::S_LOAD;
                    end
                end
                default: r_state <= bcc_pkg::S_LOAD;
            endcase
        end
    end

    always_comb begin
        m_axis_tdata          = '0;
        m_axis_tdata[7:0]     = r_col;
        m_axis_tdata[39:8]    = (w_pivot > 34'sh7FFF_FFFF) ? 32'h7FFF_FFFF :
                                (w_pivot < -34'sh8000_0000) ? 32'h8000_0000 : w_pivot[31:0];
        m_axis_tdata[71:40]   = r_stud;
        m_axis_tdata[102:72]  = r_root[31] ? 31'h7FFF_FFFF : r_root[30:0];
        m_axis_tdata[113:103] = r_cnt;
        m_axis_tdata[130:114] = r_frac;
        m_axis_tdata[131]     = (r_root == 32'd0);
    end

`ifndef SYNTHESIS
    a_ready_only_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid) else $error("input open while result pending");
    a_loaded_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded <= CW'(bcc_pkg::MaxSamples)) else $error("sample count overflow");
    a_clear_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |=> r_loaded == '0 && s_axis_tready) else $error("column not cleared");
    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> !w_rsp.busy) else $error("divider restarted while busy");
`endif

endmodule

[dv/tb_bootstrap_column_calibration_core.sv]
// Testbench for the bootstrap column calibration core.
// Columns of samples are streamed into the slave side. A scoreboard keeps its
// own copy of the sample store and the divisor, and it predicts the one result
// beat that each closing beat causes. Result beats are compared field by field
// in order. Both sides idle at random, and the divisor is changed only while
// the block is idle.
module tb_bootstrap_column_calibration_core;

    // Expected result, packed in the same order as m_axis_tdata.
    typedef struct packed {
        logic        sd_zero;
        logic [16:0] below_fraction;
        logic [10:0] below_count;
        logic [30:0] std_dev;
        logic [31:0] studentized;
        logic [31:0] basic_pivot;
        logic [7:0]  column_out;
    } t_calib_result;

    // Holds the calibration state of the block and the queue of pending results.
    class calib_scoreboard;
        int            column_samples[bcc_pkg::MaxSamples];
        longint        running_sum;
        int            stored_count;
        logic [15:0]   divisor;
        t_calib_result pending_results[$];
        int            mismatches;

        function new();
            running_sum  = 0;
            stored_count = 0;
            divisor      = bcc_pkg::DivisorReset;
            mismatches   = 0;
        endfunction

        function longint clamp32(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned root;
            longint unsigned bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (v >= root + bitv) begin
                    v    = v - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            return root;
        endfunction

        // Accepted slave beat: store it and, on a closing beat, predict the result.
        function void note_sample(logic [31:0] smp, logic [31:0] full, logic [31:0] first,
                                  logic [7:0] col, logic last);
            longint          div_eff, mean, dev, pivot, stud, full_v, first_v;
            longint unsigned acc, sq, var_v, sd, frac;
            int              cnt;
            t_calib_result   res;
            full_v  = longint'($signed(full));
            first_v = longint'($signed(first));
            if (stored_count < bcc_pkg::MaxSamples) begin
                column_samples[stored_count] = $signed(smp);
                running_sum += longint'($signed(smp));
                stored_count++;
            end
            if (!last) return;
            div_eff = (divisor < 2) ? 2 : longint'(divisor);
            mean = clamp32(running_sum / div_eff);
            acc = 0;
            for (int k = 0; k < stored_count; k++) begin
                dev = longint'(column_samples[k]) - mean;
                if (dev < 0) dev = -dev;
                sq = longint'(dev) * longint'(dev);
                acc = (acc > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF : acc + sq;
            end
            var_v = acc / longint'(div_eff - 1);
            sd = int_sqrt(var_v);
            if (sd > 64'h7FFF_FFFF) sd = 64'h7FFF_FFFF;
            pivot = 2 * full_v - first_v;
            stud = 0;
            if (sd != 0) stud = clamp32(((first_v - full_v) * 65536) / longint'(sd));
            cnt = 0;
            for (int k = 0; k < stored_count; k++)
                if (2 * first_v - longint'(column_samples[k]) < pivot) cnt++;
            frac = (longint'(cnt) * 65536) / div_eff;
            if (frac > 65536) frac = 65536;
            if (cnt > 2047) cnt = 2047;
            res.column_out     = col;
            res.basic_pivot    = 32'(clamp32(pivot));
            res.studentized    = 32'(stud);
            res.std_dev        = 31'(sd);
            res.below_count    = 11'(cnt);
            res.below_fraction = 17'(frac);
            res.sd_zero        = (sd == 0);
            pending_results.push_back(res);
            stored_count = 0;
            running_sum  = 0;
        endfunction

        function void check_result(t_calib_result got);
            t_calib_result exp_r;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: %h", got);
                mismatches++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (got.column_out !== exp_r.column_out) begin
                $error("column_out expected %0d got %0d", exp_r.column_out, got.column_out);
                mismatches++;
            end
            if (got.basic_pivot !== exp_r.basic_pivot) begin
                $error("basic_pivot expected %h got %h", exp_r.basic_pivot, got.basic_pivot);
                mismatches++;
            end
            if (got.studentized !== exp_r.studentized) begin
                $error("studentized expected %h got %h", exp_r.studentized, got.studentized);
                mismatches++;
            end
            if (got.std_dev !== exp_r.std_dev) begin
                $error("std_dev expected %h got %h", exp_r.std_dev, got.std_dev);
                mismatches++;
            end
            if (got.below_count !== exp_r.below_count) begin
                $error("below_count expected %0d got %0d", exp_r.below_count, got.below_count);
                mismatches++;
            end
            if (got.below_fraction !== exp_r.below_fraction) begin
                $error("below_fraction expected %h got %h",
                       exp_r.below_fraction, got.below_fraction);
                mismatches++;
            end
            if (got.sd_zero !== exp_r.sd_zero) begin
                $error("sd_zero expected %0d got %0d", exp_r.sd_zero, got.sd_zero);
                mismatches++;
            end
        endfunction
    endclass

    localparam int StallLimit = 20000;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [15:0]  i_cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;

    calib_scoreboard calib_sb;
    int  beats_sent;
    bit  idle_free;      // when set, neither side idles
    int  quiet_cycles;   // cycles since the last accepted beat on either side
    int  result_hold;    // remaining stall cycles on the master side

    bootstrap_column_calibration_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Sends one beat after a random gap. The valid is lowered only when a gap
    // comes, so a back-to-back beat never sees two assignments in one step.
    task automatic send_sample(logic [31:0] smp, logic [31:0] full, logic [31:0] first,
                               logic [7:0] col, logic last);
        int gap;
        gap = idle_free ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {col, first, full, smp};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        calib_sb.note_sample(smp, full, first, col, last);
        beats_sent++;
    endtask

    // Holds the sender back until every pending result has been taken, then
    // lets the closing work of any trailing beats drain.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (calib_sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_divisor(logic [15:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        calib_sb.divisor = value;
    endtask

    // Draws a sample around a center with a spread of two to the power spread_log,
    // clamped to the 32-bit signed range.
    function automatic logic [31:0] draw_near(longint center, int spread_log);
        longint v;
        v = center + (longint'($signed($urandom)) >>> (31 - spread_log));
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    // One well-formed column: estimates held, samples near a random center.
    // With noisy set, estimates change on every beat and samples are raw.
    task automatic send_column(int n, bit noisy);
        logic [31:0] full, first;
        logic [7:0]  col;
        longint      center;
        int          spread;
        full   = $urandom;
        first  = $urandom;
        col    = 8'($urandom);
        if ($urandom_range(0, 3) != 0) begin
            full  = draw_near(0, $urandom_range(8, 28));
            first = draw_near(longint'($signed(full)), $urandom_range(4, 24));
        end
        center = longint'($signed(first));
        spread = $urandom_range(0, 31);
        for (int k = 0; k < n; k++) begin
            if (noisy) begin
                full  = $urandom;
                first = $urandom;
            end
            send_sample(noisy ? $urandom : draw_near(center, spread),
                        full, first, col, k == n - 1);
        end
    endtask

    // Master side: unless idle_free is set, a random stall is drawn for every
    // result beat, and the scoreboard checks each beat as it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                calib_sb.check_result(m_axis_tdata[131:0]);
                result_hold = idle_free ? 0 : $urandom_range(0, 15);
                if (result_hold > 0) m_axis_tready <= 1'b0;
            end else if (result_hold > 0) begin
                result_hold--;
                if (result_hold == 0) m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: a long stretch with no accepted beat on either side ends the run.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        logic [15:0] div_choice;
        calib_sb      = new();
        beats_sent    = 0;
        idle_free     = 1'b0;
        quiet_cycles  = 0;
        result_hold   = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, under the reset divisor first.
        // Extreme samples and extreme estimates, so the pivot saturates.
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 8'd0, 1'b0);
        send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 8'd255, 1'b1);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 8'd1, 1'b0);
        send_sample(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 8'd2, 1'b1);
        // Identical samples; sd is not zero, as the mean divides by the divisor.
        for (int k = 0; k < 3; k++)
            send_sample(32'h0001_0000, 32'h0002_0000, 32'h0001_8000, 8'd3, k == 2);
        // A single-sample column.
        send_sample(32'hFFFF_0000, 32'h0000_0000, 32'hFFFF_FFFF, 8'd4, 1'b1);

        // The smallest divisor, with counts well above it so the fraction saturates.
        write_divisor(16'd2);
        for (int k = 0; k < 6; k++)
            send_sample(32'h0010_0000 + k, 32'h0000_0000, 32'h0000_8000, 8'd5, k == 5);
        // Divisors of zero and one both act as two.
        write_divisor(16'd0);
        send_column(4, 1'b0);
        write_divisor(16'd1);
        send_column(4, 1'b0);
        write_divisor(16'd65535);
        send_column(5, 1'b0);

        // A column that overflows the store; the closing beat still closes it.
        write_divisor(16'd1024);
        idle_free = 1'b1;
        send_column(bcc_pkg::MaxSamples + 6, 1'b0);
        idle_free = 1'b0;

        // Random part: well-formed columns, mostly short, some noisy, a few long.
        while (beats_sent < 1800) begin
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 5))
                    0: div_choice = 16'd2;
                    1: div_choice = 16'd65535;
                    2: div_choice = 16'($urandom_range(0, 1));
                    3: div_choice = 16'($urandom);
                    default: div_choice = 16'($urandom_range(3, 40));
                endcase
                write_divisor(div_choice);
            end
            idle_free = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 49) == 0)
                send_column($urandom_range(100, 600), 1'b0);
            else
                send_column($urandom_range(1, 24), $urandom_range(0, 9) == 0);
        end
        idle_free = 1'b0;

        wait_drained();
        repeat (300) @(posedge i_clk);
        if (calib_sb.pending_results.size() != 0) begin
            $error("%0d results still expected", calib_sb.pending_results.size());
            calib_sb.mismatches++;
        end
        if (calib_sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

[files.f]
design/bcc_pkg.sv
design/bcc_ram.sv
design/bcc_div.sv
design/bootstrap_column_calibration_core.sv
dv/tb_bootstrap_column_calibration_core.sv
